@@ rtl/backslash_escape_codec_top_defines.svh @@
`ifndef BACKSLASH_ESCAPE_CODEC_TOP_DEFINES_SVH
`define BACKSLASH_ESCAPE_CODEC_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BEC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define BEC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bec_pkg.sv @@
`default_nettype none

package bec_pkg;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_S      = 8'h73;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NL     = 8'h0A;

	localparam int unsigned QUEUE_DEPTH = 4;

	typedef enum logic {
		MODE_ESCAPE   = 1'b0,
		MODE_UNESCAPE = 1'b1
	} mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_last;
		logic       bad_escape;
		logic       message_ok;
	} out_item_t;

	// one classified input: one result, or two when a special byte is escaped
	typedef struct packed {
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic       two;
		logic       valid;
		logic       last;
		logic       bad;
		logic       ok;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

`default_nettype wire

@@ rtl/bec_queue.sv @@
`default_nettype none

module bec_queue import bec_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire job_t        wr_job,
	input  wire logic        pop,
	output job_t             rd_job,
	output queue_stat_t      stat
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t            mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign rd_job     = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

`default_nettype wire

@@ rtl/bec_front.sv @@
`default_nettype none

module bec_front import bec_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     mode_we,
	input  wire logic     mode_wdata,
	input  wire logic     item_valid,
	output logic          item_stall,
	input  wire in_item_t item,
	input  wire logic     queue_full,
	output logic          push,
	output job_t          job
);

	mode_t mode_q;
	logic  pend_q;
	logic  err_q;
	logic  accept;
	logic  want_push;
	logic  pend_d;
	logic  err_d;
	logic  [7:0] b;
	logic  last;

	assign b          = item.in_byte;
	assign last       = item.in_last;
	assign item_stall = queue_full;
	assign accept     = item_valid && !queue_full;
	assign push       = accept && want_push;

	always_comb begin
		job        = '0;
		want_push  = 1'b1;
		pend_d     = pend_q;
		err_d      = err_q;
		job.valid  = 1'b1;
		job.last   = last;
		job.first_byte = b;
		unique case (mode_q)
			MODE_ESCAPE: begin
				job.two = 1'b1;
				unique case (b)
					CH_BSLASH: job.second_byte = CH_BSLASH;
					CH_NL:     job.second_byte = CH_N;
					CH_SPACE:  job.second_byte = CH_S;
					default:   job.two = 1'b0;
				endcase
				if (job.two) begin
					job.first_byte = CH_BSLASH;
				end
				job.ok = last && !err_q;
			end
			MODE_UNESCAPE: begin
				if (pend_q) begin
					pend_d = 1'b0;
					unique case (b)
						CH_S:      job.first_byte = CH_SPACE;
						CH_N:      job.first_byte = CH_NL;
						CH_BSLASH: job.first_byte = CH_BSLASH;
						default: begin
							job.bad = 1'b1;
							err_d   = 1'b1;
						end
					endcase
					job.ok = last && !err_d;
				end else if (b == CH_BSLASH) begin
					if (last) begin
						err_d          = 1'b1;
						job.first_byte = '0;
						job.valid      = 1'b0;
						job.bad        = 1'b1;
					end else begin
						pend_d    = 1'b1;
						want_push = 1'b0;
					end
				end else begin
					job.ok = last && !err_q;
				end
			end
			default: want_push = 1'b0;
		endcase
		if (last) begin
			pend_d = 1'b0;
			err_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ESCAPE;
			pend_q <= 1'b0;
			err_q  <= 1'b0;
		end else begin
			if (mode_we) begin
				mode_q <= mode_t'(mode_wdata);
			end
			if (accept) begin
				pend_q <= pend_d;
				err_q  <= err_d;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/bec_back.sv @@
`default_nettype none

module bec_back import bec_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire job_t      job,
	input  wire logic      queue_empty,
	output logic           pop,
	output logic           result_valid,
	input  wire logic      result_stall,
	output out_item_t      result
);

	logic      phase_q;
	logic      result_valid_q;
	out_item_t result_q;
	logic      load;
	logic      emit;
	logic      first_half;
	out_item_t next_res;

	assign load       = !result_valid_q || !result_stall;
	assign emit       = load && !queue_empty;
	assign first_half = job.two && !phase_q;
	assign pop        = emit && !first_half;

	always_comb begin
		next_res = '0;
		priority if (first_half) begin
			next_res.out_byte  = CH_BSLASH;
			next_res.out_valid = 1'b1;
		end else if (job.two) begin
			next_res.out_byte   = job.second_byte;
			next_res.out_valid  = 1'b1;
			next_res.out_last   = job.last;
			next_res.message_ok = job.ok;
		end else begin
			next_res.out_byte   = job.first_byte;
			next_res.out_valid  = job.valid;
			next_res.out_last   = job.last;
			next_res.bad_escape = job.bad;
			next_res.message_ok = job.ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (load) begin
				result_valid_q <= !queue_empty;
			end
			if (emit) begin
				phase_q <= first_half;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= next_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

@@ rtl/backslash_escape_codec_top.sv @@
// Backslash escape codec. With mode 0 each input byte gives one result, or two for backslash,
// newline and space (backslash-backslash, backslash-n, backslash-s); with mode 1 escapes are
// undone, a lone backslash gives no result, an unknown or trailing escape is flagged in
// bad_escape and message_ok on the last result of the message is set only if none was seen.
// An input transaction is taken every cycle while the queue has room; every result occupies the
// single output register, which holds it while result_stall is high, so an escaped special byte
// leaves as two results and everything else as one. Each input passes the queue and then the
// output register before its first result appears. Write mode only while the codec is idle.
`default_nettype none

`include "backslash_escape_codec_top_defines.svh"

module backslash_escape_codec_top import bec_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = QUEUE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     mode_we,
	input  wire logic     mode_wdata,
	input  wire logic     item_valid,
	output logic          item_stall,
	input  wire in_item_t item,
	output logic          result_valid,
	input  wire logic     result_stall,
	output out_item_t     result
);

	job_t        wr_job;
	job_t        rd_job;
	logic        push;
	logic        pop;
	queue_stat_t stat;

	bec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode_we    (mode_we),
		.mode_wdata (mode_wdata),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.queue_full (stat.full),
		.push       (push),
		.job        (wr_job)
	);

	bec_queue #(
		.DEPTH (FIFO_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.stat   (stat)
	);

	bec_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (rd_job),
		.queue_empty  (stat.empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	`BEC_ASSERT_IMP(a_push_not_full, push, !stat.full, "push into a full queue")
	`BEC_ASSERT_IMP(a_pop_not_empty, pop, !stat.empty, "pop from an empty queue")
	`BEC_ASSERT_IMP(a_empty_marker, result_valid && !result.out_valid, result.out_last && result.bad_escape && (result.out_byte == 8'h00), "malformed empty end marker")
	`BEC_ASSERT_IMP(a_ok_on_last, result_valid && result.message_ok, result.out_last && !result.bad_escape, "message_ok off the clean last result")

endmodule

`default_nettype wire

@@ tb/backslash_escape_codec_top_tb.sv @@
module backslash_escape_codec_top_tb import bec_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES  = 6;
	localparam int TAIL_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_BYTES    = 200;
	localparam int PHASES         = 8;

	class codec_scoreboard;
		mode_t       mode;
		bit          esc_pending;
		bit          err_seen;
		out_item_t   expected_out[$];
		int          mismatches;
		int          checked;

		function new();
			mode = MODE_ESCAPE;
			esc_pending = 1'b0;
			err_seen = 1'b0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void queue_result(logic [7:0] b, logic v, logic l, logic bad, logic ok);
			out_item_t r;
			r.out_byte = b;
			r.out_valid = v;
			r.out_last = l;
			r.bad_escape = bad;
			r.message_ok = ok;
			expected_out.push_back(r);
		endfunction

		function void note_byte(in_item_t it);
			logic [7:0] pair;
			logic [7:0] o;
			logic       bad;
			logic       l;
			bit         two;
			l = it.in_last;
			if (mode == MODE_ESCAPE) begin
				two = 1'b1;
				pair = 8'h00;
				case (it.in_byte)
					CH_BSLASH: pair = CH_BSLASH;
					CH_NL:     pair = CH_N;
					CH_SPACE:  pair = CH_S;
					default:   two = 1'b0;
				endcase
				if (two) begin
					queue_result(CH_BSLASH, 1'b1, 1'b0, 1'b0, 1'b0);
					queue_result(pair, 1'b1, l, 1'b0, l && !err_seen);
				end else begin
					queue_result(it.in_byte, 1'b1, l, 1'b0, l && !err_seen);
				end
			end else if (esc_pending) begin
				bad = 1'b0;
				case (it.in_byte)
					CH_S:      o = CH_SPACE;
					CH_N:      o = CH_NL;
					CH_BSLASH: o = CH_BSLASH;
					default: begin
						o = it.in_byte;
						bad = 1'b1;
						err_seen = 1'b1;
					end
				endcase
				esc_pending = 1'b0;
				queue_result(o, 1'b1, l, bad, l && !err_seen);
			end else if (it.in_byte == CH_BSLASH) begin
				if (l) begin
					err_seen = 1'b1;
					queue_result(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
				end else begin
					esc_pending = 1'b1;
				end
			end else begin
				queue_result(it.in_byte, 1'b1, l, 1'b0, l && !err_seen);
			end
			if (l) begin
				esc_pending = 1'b0;
				err_seen = 1'b0;
			end
		endfunction

		function void note_mismatch(string what, out_item_t want, out_item_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t mismatch (%s): expected byte %02h valid %b last %b bad %b ok %b",
					$time, what, want.out_byte, want.out_valid, want.out_last,
					want.bad_escape, want.message_ok);
				$display("    got byte %02h valid %b last %b bad %b ok %b",
					got.out_byte, got.out_valid, got.out_last, got.bad_escape,
					got.message_ok);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_out.size() == 0) begin
				note_mismatch("no result due", '0, got);
				return;
			end
			want = expected_out.pop_front();
			checked++;
			if (got.out_byte !== want.out_byte || got.out_valid !== want.out_valid ||
				got.out_last !== want.out_last || got.bad_escape !== want.bad_escape ||
				got.message_ok !== want.message_ok)
				note_mismatch("wrong field", want, got);
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      mode_we;
	logic      mode_wdata;
	logic      item_valid;
	logic      item_stall;
	in_item_t  item;
	logic      result_valid;
	logic      result_stall;
	out_item_t result;

	codec_scoreboard sb;
	bit calm = 1'b0;
	int items_in = 0;
	int mode_writes = 0;

	backslash_escape_codec_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode_we      (mode_we),
		.mode_wdata   (mode_wdata),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				sb.note_byte(item);
				items_in++;
			end
			if (result_valid && !result_stall)
				sb.check_result(result);
		end
	end

	initial begin : stall_drive
		int n;
		result_stall = 1'b0;
		wait (arst_n);
		forever begin
			n = pick_gap();
			@(negedge clk);
			result_stall <= (n != 0);
			repeat ((n > 0) ? n - 1 : 0) @(negedge clk);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle = 0;
			else
				idle++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic l);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= '{in_byte: b, in_last: l};
		do @(posedge clk); while (item_stall);
		@(negedge clk);
	endtask

	task automatic write_mode(input mode_t m);
		item_valid <= 1'b0;
		while (sb.expected_out.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		mode_we <= 1'b1;
		mode_wdata <= m;
		@(negedge clk);
		mode_we <= 1'b0;
		sb.mode = m;
		mode_writes++;
	endtask

	task automatic send_message(input mode_t m, input bit close);
		logic [7:0] msg[$];
		logic [7:0] b;
		int pieces;
		int k;
		int r;
		if ($urandom_range(0, 19) == 0)
			pieces = $urandom_range(13, 30);
		else
			pieces = $urandom_range(1, 8);
		for (k = 0; k < pieces; k++) begin
			r = $urandom_range(0, 99);
			if (m == MODE_ESCAPE) begin
				if (r < 30) begin
					case ($urandom_range(0, 2))
						0:       b = CH_BSLASH;
						1:       b = CH_NL;
						default: b = CH_SPACE;
					endcase
				end else begin
					b = 8'($urandom_range(0, 255));
				end
				msg.push_back(b);
			end else if (r < 45) begin
				do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
				msg.push_back(b);
			end else if (r < 88) begin
				case ($urandom_range(0, 2))
					0:       b = CH_S;
					1:       b = CH_N;
					default: b = CH_BSLASH;
				endcase
				msg.push_back(CH_BSLASH);
				msg.push_back(b);
			end else begin
				msg.push_back(CH_BSLASH);
				msg.push_back(8'($urandom_range(0, 255)));
			end
		end
		if (m == MODE_UNESCAPE && $urandom_range(0, 9) == 0)
			msg.push_back(CH_BSLASH);
		for (k = 0; k < msg.size(); k++)
			send_byte(msg[k], close && (k == msg.size() - 1));
	endtask

	initial begin : main
		int ph;
		int start;
		mode_t m;
		sb = new();
		arst_n = 1'b0;
		mode_we = 1'b0;
		mode_wdata = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// escape mode straight out of reset
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_BSLASH, 1'b0);
		send_byte(CH_NL, 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_byte(8'h41, 1'b1);
		send_byte(CH_SPACE, 1'b1);

		write_mode(MODE_UNESCAPE);
		send_byte(CH_BSLASH, 1'b0);
		send_byte(CH_N, 1'b0);
		send_byte(CH_BSLASH, 1'b0);
		send_byte(CH_S, 1'b0);
		send_byte(CH_BSLASH, 1'b0);
		send_byte(CH_BSLASH, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(CH_BSLASH, 1'b0);
		send_byte(8'h71, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(CH_BSLASH, 1'b1);
		send_byte(CH_BSLASH, 1'b0);
		send_byte(8'hFF, 1'b1);

		// switch mode mid-message: error and pending escape must survive
		send_byte(CH_BSLASH, 1'b0);
		send_byte(8'h7A, 1'b0);
		write_mode(MODE_ESCAPE);
		send_byte(CH_SPACE, 1'b1);
		write_mode(MODE_UNESCAPE);
		send_byte(CH_BSLASH, 1'b0);
		write_mode(MODE_ESCAPE);
		send_byte(8'h61, 1'b0);
		write_mode(MODE_UNESCAPE);
		send_byte(CH_N, 1'b1);

		for (ph = 0; ph < PHASES; ph++) begin
			m = mode_t'(ph % 2);
			calm = (ph == 3 || ph == 6);
			write_mode(m);
			start = items_in;
			while (items_in - start < PHASE_BYTES)
				send_message(m, 1'b1);
			if ($urandom_range(0, 2) == 0)
				send_message(m, 1'b0);
		end
		calm = 1'b0;

		item_valid <= 1'b0;
		while (sb.expected_out.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d bytes over %0d mode writes in both directions, checked %0d results",
			items_in, mode_writes, sb.checked);
		$display("Mismatches: %0d, results still due: %0d", sb.mismatches,
			sb.expected_out.size());
		if (sb.mismatches == 0 && sb.expected_out.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bec_pkg.sv
rtl/bec_queue.sv
rtl/bec_front.sv
rtl/bec_back.sv
rtl/backslash_escape_codec_top.sv
tb/backslash_escape_codec_top_tb.sv
